FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared constants and types for the epoch seconds calendar converter
// Holds field widths, the reciprocal constants used for exact division by
// constants, and the month term table.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // Field widths.
    localparam int SEC_W  = 38;
    localparam int YEAR_W = 14;
    localparam int JDN_W  = 25;

    // Reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k, with k = n + clog2(d).
    // Seconds / 86400 is done as (seconds >> 7) / 675 on 31 bits.
    localparam logic [31:0] M_DAY  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
    // 4p / 146097 with 4p below 2^25.
    localparam logic [25:0] M_CENT = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
    // 4000(r + 1) / 1461001 with the dividend below 2^30.
    localparam logic [30:0] M_YEAR = 31'(((64'd1 << 51) + 64'd1461000) / 64'd1461001);
    // Time of day / 3600 on 17 bits.
    localparam logic [17:0] M_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    // Seconds of the hour / 60 on 12 bits.
    localparam logic [12:0] M_MIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    // 80t / 2447 on 18 bits.
    localparam logic [18:0] M_MON  = 19'(((64'd1 << 30) + 64'd2446) / 64'd2447);
    // Value / 5 on 13 bits.
    localparam logic [13:0] M_FIVE = 14'(((64'd1 << 16) + 64'd4) / 64'd5);
    // (y + 100) / 100 on 15 bits.
    localparam logic [15:0] M_HUND = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
    // Julian day / 7 on 25 bits.
    localparam logic [25:0] M_WEEK = 26'(((64'd1 << 28) + 64'd6) / 64'd7);

    // Request fields as they travel beside the arithmetic.
    typedef struct packed {
        logic              action;
        logic [SEC_W-1:0]  seconds;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } req_t;

    // floor(367 * (month - 2 - 12m) / 12), where m is -1 for months up to February.
    function automatic logic [8:0] month_term(input logic [3:0] month);
        logic [8:0] val;
        case (month)
            4'd0:    val = 9'd305;
            4'd1:    val = 9'd336;
            4'd2:    val = 9'd367;
            4'd3:    val = 9'd30;
            4'd4:    val = 9'd61;
            4'd5:    val = 9'd91;
            4'd6:    val = 9'd122;
            4'd7:    val = 9'd152;
            4'd8:    val = 9'd183;
            4'd9:    val = 9'd214;
            4'd10:   val = 9'd244;
            4'd11:   val = 9'd275;
            4'd12:   val = 9'd305;
            4'd13:   val = 9'd336;
            4'd14:   val = 9'd367;
            default: val = 9'd397;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/esc_s2c.sv
// ----------------------------------------------------------------------------
// esc_s2c: seconds to calendar pipeline
// Eight register stages split a second count into date and time of day.
// The Julian day number leaves after stage three for the weekday unit.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_s2c (
    input  wire logic                         clk,
    input  wire logic [esc_pkg::SEC_W-1:0]    secs,
    output logic      [esc_pkg::JDN_W-1:0]    jdn,
    output logic      [esc_pkg::YEAR_W-1:0]   year,
    output logic      [3:0]                   month,
    output logic      [4:0]                   day,
    output logic      [4:0]                   hour,
    output logic      [5:0]                   minute,
    output logic      [5:0]                   second
);

    // Stage 1: whole days.
    logic [62:0] dprod;
    logic [21:0] days1_next, days1_reg;
    logic [37:0] secs1_reg;

    assign dprod      = 63'(secs[37:7]) * 63'(esc_pkg::M_DAY);
    assign days1_next = dprod[62:41];

    // Stage 2: time of day, shifted day count and the 400-year cycle.
    logic [37:0] tfull;
    logic [22:0] p_next, p2_reg, wdx2_next, wdx2_reg;
    logic [50:0] qprod;
    logic [7:0]  q2_next, q2_reg;
    logic [16:0] tod2_next, tod2_reg;

    assign tfull     = secs1_reg - 38'(days1_reg) * 38'd86400;
    assign tod2_next = tfull[16:0];
    assign p_next    = 23'(days1_reg) + 23'd2483588;
    assign qprod     = 51'({p_next, 2'b00}) * 51'(esc_pkg::M_CENT);
    assign q2_next   = qprod[50:43];
    assign wdx2_next = 23'(days1_reg) + 23'd2415019;

    // Stage 3: day within the cycle and the hour.
    logic [24:0] rsub;
    logic [17:0] r3_next, r3_reg;
    logic [34:0] hprod;
    logic [4:0]  hr3_next, hr3_reg;
    logic [13:0] yb3_next, yb3_reg;
    logic [16:0] tod3_reg;
    logic [22:0] wdx3_reg;

    assign rsub     = 25'(p2_reg) - ((25'(q2_reg) * 25'd146097 + 25'd3) >> 2);
    assign r3_next  = rsub[17:0];
    assign hprod    = 35'(tod2_reg) * 35'(esc_pkg::M_HOUR);
    assign hr3_next = hprod[33:29];
    assign yb3_next = 14'(q2_reg) * 14'd100 - 14'd4900;

    // Stage 4: year within the cycle and the seconds of the hour.
    logic [29:0] sx;
    logic [60:0] sprod;
    logic [8:0]  s4_next, s4_reg;
    logic [16:0] remf;
    logic [11:0] rem4_next, rem4_reg;
    logic [17:0] r4_reg;
    logic [4:0]  hr4_reg;
    logic [13:0] yb4_reg;

    assign sx        = (30'(r3_reg) + 30'd1) * 30'd4000;
    assign sprod     = 61'(sx) * 61'(esc_pkg::M_YEAR);
    assign s4_next   = sprod[59:51];
    assign remf      = tod3_reg - 17'(hr3_reg) * 17'd3600;
    assign rem4_next = remf[11:0];

    // Stage 5: day within the year and the minute.
    logic [19:0] tsum;
    logic [10:0] t5_next, t5_reg;
    logic [24:0] mprod;
    logic [5:0]  mn5_next, mn5_reg;
    logic [13:0] y5_next, y5_reg;
    logic [11:0] rem5_reg;
    logic [4:0]  hr5_reg;

    assign tsum     = 20'(r4_reg) + 20'd31 - ((20'(s4_reg) * 20'd1461) >> 2);
    assign t5_next  = tsum[10:0];
    assign mprod    = 25'(rem4_reg) * 25'(esc_pkg::M_MIN);
    assign mn5_next = mprod[23:18];
    assign y5_next  = yb4_reg + 14'(s4_reg);

    // Stage 6: month index and the second.
    logic [17:0] ux;
    logic [36:0] uprod;
    logic [4:0]  u6_next, u6_reg;
    logic [11:0] scf;
    logic [5:0]  sc6_next, sc6_reg;
    logic [10:0] t6_reg;
    logic [13:0] y6_reg;
    logic [4:0]  hr6_reg;
    logic [5:0]  mn6_reg;

    assign ux       = 18'(t5_reg) * 18'd80;
    assign uprod    = 37'(ux) * 37'(esc_pkg::M_MON);
    assign u6_next  = uprod[34:30];
    assign scf      = rem5_reg - 12'(mn5_reg) * 12'd60;
    assign sc6_next = scf[5:0];

    // Stage 7: year and month, and the month start term.
    logic        v7;
    logic [13:0] year7_next, year7_reg;
    logic [4:0]  mon7;
    logic [3:0]  month7_next, month7_reg;
    logic [16:0] xprod;
    logic [12:0] x7_next, x7_reg;
    logic [10:0] t7_reg;
    logic [4:0]  hr7_reg;
    logic [5:0]  mn7_reg, sc7_reg;

    assign v7          = (u6_reg >= 5'd11);
    assign year7_next  = y6_reg + 14'(v7);
    assign mon7        = u6_reg + 5'd2 - (v7 ? 5'd12 : 5'd0);
    assign month7_next = mon7[3:0];
    assign xprod       = 17'(u6_reg) * 17'd2447;
    assign x7_next     = xprod[16:4];

    // Stage 8: day of month.
    logic [26:0] fprod;
    logic [10:0] dsub;
    logic [4:0]  day8_next, day8_reg;
    logic [13:0] year8_reg;
    logic [3:0]  month8_reg;
    logic [4:0]  hr8_reg;
    logic [5:0]  mn8_reg, sc8_reg;

    assign fprod     = 27'(x7_reg) * 27'(esc_pkg::M_FIVE);
    assign dsub      = t7_reg - fprod[26:16];
    assign day8_next = dsub[4:0];

    // Stage registers advance every cycle.
    always_ff @(posedge clk)
    begin
        days1_reg  <= days1_next;
        secs1_reg  <= secs;
        p2_reg     <= p_next;
        q2_reg     <= q2_next;
        tod2_reg   <= tod2_next;
        wdx2_reg   <= wdx2_next;
        r3_reg     <= r3_next;
        hr3_reg    <= hr3_next;
        yb3_reg    <= yb3_next;
        tod3_reg   <= tod2_reg;
        wdx3_reg   <= wdx2_reg;
        s4_reg     <= s4_next;
        rem4_reg   <= rem4_next;
        r4_reg     <= r3_reg;
        hr4_reg    <= hr3_reg;
        yb4_reg    <= yb3_reg;
        t5_reg     <= t5_next;
        mn5_reg    <= mn5_next;
        y5_reg     <= y5_next;
        rem5_reg   <= rem4_reg;
        hr5_reg    <= hr4_reg;
        u6_reg     <= u6_next;
        sc6_reg    <= sc6_next;
        t6_reg     <= t5_reg;
        y6_reg     <= y5_reg;
        hr6_reg    <= hr5_reg;
        mn6_reg    <= mn5_reg;
        year7_reg  <= year7_next;
        month7_reg <= month7_next;
        x7_reg     <= x7_next;
        t7_reg     <= t6_reg;
        hr7_reg    <= hr6_reg;
        mn7_reg    <= mn6_reg;
        sc7_reg    <= sc6_reg;
        day8_reg   <= day8_next;
        year8_reg  <= year7_reg;
        month8_reg <= month7_reg;
        hr8_reg    <= hr7_reg;
        mn8_reg    <= mn7_reg;
        sc8_reg    <= sc7_reg;
    end

    assign jdn    = 25'(wdx3_reg);
    assign year   = year8_reg;
    assign month  = month8_reg;
    assign day    = day8_reg;
    assign hour   = hr8_reg;
    assign minute = mn8_reg;
    assign second = sc8_reg;

endmodule

`default_nettype wire

FILE: rtl/esc_c2s.sv
// ----------------------------------------------------------------------------
// esc_c2s: calendar to seconds pipeline
// Eight register stages combine date and time into a second count.
// The Julian day number leaves after stage three for the weekday unit.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_c2s (
    input  wire logic                         clk,
    input  wire logic [esc_pkg::YEAR_W-1:0]   year,
    input  wire logic [3:0]                   month,
    input  wire logic [4:0]                   day,
    input  wire logic [4:0]                   hour,
    input  wire logic [5:0]                   minute,
    input  wire logic [5:0]                   second,
    output logic      [esc_pkg::JDN_W-1:0]    jdn,
    output logic      [esc_pkg::SEC_W-1:0]    seconds,
    output logic                              oor
);

    // Stage 1: shifted year, month term and time of day.
    logic        early;
    logic [14:0] ym1_next, ym1_reg;
    logic [8:0]  b1_reg;
    logic [16:0] tod1_next, tod1_reg;
    logic [4:0]  day1_reg;

    assign early     = (month <= 4'd2);
    assign ym1_next  = 15'(year) + 15'd4800 - 15'(early);
    assign tod1_next = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);

    // Stage 2: leap day count and century count.
    logic [26:0] aprod;
    logic [24:0] a2_next, a2_reg;
    logic [30:0] cprod;
    logic [7:0]  c2_next, c2_reg;
    logic [8:0]  b2_reg;
    logic [16:0] tod2_reg;
    logic [4:0]  day2_reg;

    assign aprod   = 27'(ym1_reg) * 27'd1461;
    assign a2_next = aprod[26:2];
    assign cprod   = 31'(ym1_reg + 15'd100) * 31'(esc_pkg::M_HUND);
    assign c2_next = cprod[29:22];

    // Stage 3: day count from the epoch and the Julian day number.
    logic [9:0]  cc;
    logic [26:0] days3_next, days3_reg;
    logic [26:0] jsum;
    logic [24:0] jdn3_next, jdn3_reg;
    logic [16:0] tod3_reg;

    assign cc         = (10'(c2_reg) * 10'd3) >> 2;
    assign days3_next = 27'(a2_reg) + 27'(b2_reg) + 27'(day2_reg) - 27'(cc) - 27'd2447094;
    assign jsum       = days3_next + 27'd2415019 + 27'(tod2_reg >= 17'd86400);
    assign jdn3_next  = jsum[24:0];

    // Stage 4: total seconds, or zero before the epoch.
    logic [41:0] sprod;
    logic [37:0] sec4_next, sec4_reg;
    logic        oor4_next, oor4_reg;

    assign sprod     = 42'(days3_reg[24:0]) * 42'd86400 + 42'(tod3_reg);
    assign oor4_next = days3_reg[26];
    assign sec4_next = oor4_next ? 38'd0 : sprod[37:0];

    // Stages 5 to 8 align the result with the other path.
    logic [37:0] sec_dly_reg [0:3];
    logic        oor_dly_reg [0:3];

    always_ff @(posedge clk)
    begin
        ym1_reg  <= ym1_next;
        b1_reg   <= esc_pkg::month_term(month);
        tod1_reg <= tod1_next;
        day1_reg <= day;
        a2_reg   <= a2_next;
        c2_reg   <= c2_next;
        b2_reg   <= b1_reg;
        tod2_reg <= tod1_reg;
        day2_reg <= day1_reg;
        days3_reg <= days3_next;
        jdn3_reg <= jdn3_next;
        tod3_reg <= tod2_reg;
        sec4_reg <= sec4_next;
        oor4_reg <= oor4_next;
        sec_dly_reg[0] <= sec4_reg;
        oor_dly_reg[0] <= oor4_reg;
        for (int i = 1; i < 4; i++)
        begin
            sec_dly_reg[i] <= sec_dly_reg[i-1];
            oor_dly_reg[i] <= oor_dly_reg[i-1];
        end
    end

    assign jdn     = jdn3_reg;
    assign seconds = sec_dly_reg[3];
    assign oor     = oor_dly_reg[3];

endmodule

`default_nettype wire

FILE: rtl/esc_wday.sv
// ----------------------------------------------------------------------------
// esc_wday: weekday unit
// Takes a Julian day number in stage four, reduces it modulo seven and
// carries the weekday and weekend flag through stage eight.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_wday (
    input  wire logic                         clk,
    input  wire logic [esc_pkg::JDN_W-1:0]    jdn,
    output logic      [2:0]                   weekday,
    output logic                              is_weekend
);

    // Stage 4: quotient by seven.
    logic [50:0] qprod;
    logic [22:0] q4_reg;
    logic [24:0] x4_reg;

    assign qprod = 51'(jdn) * 51'(esc_pkg::M_WEEK);

    // Stage 5: remainder gives the weekday.
    logic [24:0] rem;
    logic [2:0]  wd5_next;

    assign rem      = x4_reg - 25'(q4_reg) * 25'd7;
    assign wd5_next = rem[2:0] + 3'd1;

    // Stages 5 to 8 hold the weekday in line with the calendar results.
    logic [2:0] wd_dly_reg [0:3];
    logic       we_dly_reg [0:3];

    always_ff @(posedge clk)
    begin
        q4_reg        <= qprod[50:28];
        x4_reg        <= jdn;
        wd_dly_reg[0] <= wd5_next;
        we_dly_reg[0] <= (wd5_next > 3'd5);
        for (int i = 1; i < 4; i++)
        begin
            wd_dly_reg[i] <= wd_dly_reg[i-1];
            we_dly_reg[i] <= we_dly_reg[i-1];
        end
    end

    assign weekday    = wd_dly_reg[3];
    assign is_weekend = we_dly_reg[3];

endmodule

`default_nettype wire

FILE: rtl/epoch_seconds_calendar_convert.sv
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_convert: epoch seconds to calendar converter
// Converts between seconds since 1899-12-30 00:00:00 and a Gregorian date
// and time of day, and reports the weekday and a weekend flag.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken on every rising edge with start high; busy is always
// low, so a new request may follow in every cycle. action 0 converts
// seconds_in to a date and time, action 1 converts the date and time fields
// to seconds. The fields that the action does not compute are echoed.
// Each result appears on the output ports for one cycle with done high.
// Throughput is one request per cycle: eight arithmetic stages, each with
// at most one multiplier by a reciprocal constant, plus the output register.
// The receiver cannot stall, so results are never held back. Reset clears
// only the valid bits; no result is produced until a request is taken. A
// date in action 1 before the epoch gives seconds_out zero with
// out_of_range high.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_calendar_convert (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         action,
    input  wire logic [esc_pkg::SEC_W-1:0]    seconds_in,
    input  wire logic [esc_pkg::YEAR_W-1:0]   year_in,
    input  wire logic [3:0]                   month_in,
    input  wire logic [4:0]                   day_in,
    input  wire logic [4:0]                   hour_in,
    input  wire logic [5:0]                   minute_in,
    input  wire logic [5:0]                   second_in,
    output logic                              done,
    output logic      [esc_pkg::SEC_W-1:0]    seconds_out,
    output logic      [esc_pkg::YEAR_W-1:0]   year_out,
    output logic      [3:0]                   month_out,
    output logic      [4:0]                   day_out,
    output logic      [4:0]                   hour_out,
    output logic      [5:0]                   minute_out,
    output logic      [5:0]                   second_out,
    output logic      [2:0]                   weekday,
    output logic                              is_weekend,
    output logic                              out_of_range
);

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Request fields, captured for the echo and the path select.
    esc_pkg::req_t req_in;
    esc_pkg::req_t req_dly_reg [0:7];

    assign req_in = '{action: action, seconds: seconds_in, year: year_in,
                      month: month_in, day: day_in, hour: hour_in,
                      minute: minute_in, second: second_in};

    // Valid bits for stages one to eight and the output register.
    logic [8:0] vld_next, vld_reg;

    assign vld_next = {vld_reg[7:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_dly_reg[0] <= req_in;
        for (int i = 1; i < 8; i++)
        begin
            req_dly_reg[i] <= req_dly_reg[i-1];
        end
    end

    // Seconds to calendar path.
    logic [esc_pkg::JDN_W-1:0]  s2c_jdn;
    logic [esc_pkg::YEAR_W-1:0] s2c_year;
    logic [3:0]                 s2c_month;
    logic [4:0]                 s2c_day;
    logic [4:0]                 s2c_hour;
    logic [5:0]                 s2c_minute;
    logic [5:0]                 s2c_second;

    esc_s2c u_s2c (
        .clk    (clk),
        .secs   (seconds_in),
        .jdn    (s2c_jdn),
        .year   (s2c_year),
        .month  (s2c_month),
        .day    (s2c_day),
        .hour   (s2c_hour),
        .minute (s2c_minute),
        .second (s2c_second)
    );

    // Calendar to seconds path.
    logic [esc_pkg::JDN_W-1:0] c2s_jdn;
    logic [esc_pkg::SEC_W-1:0] c2s_seconds;
    logic                      c2s_oor;

    esc_c2s u_c2s (
        .clk     (clk),
        .year    (year_in),
        .month   (month_in),
        .day     (day_in),
        .hour    (hour_in),
        .minute  (minute_in),
        .second  (second_in),
        .jdn     (c2s_jdn),
        .seconds (c2s_seconds),
        .oor     (c2s_oor)
    );

    // Shared weekday unit fed by the path of the request in stage three.
    logic [esc_pkg::JDN_W-1:0] wd_jdn;
    logic [2:0]                wd_day;
    logic                      wd_weekend;

    assign wd_jdn = req_dly_reg[2].action ? c2s_jdn : s2c_jdn;

    esc_wday u_wday (
        .clk        (clk),
        .jdn        (wd_jdn),
        .weekday    (wd_day),
        .is_weekend (wd_weekend)
    );

    // Output register: computed fields or echoes, by action.
    esc_pkg::req_t last;
    logic [esc_pkg::SEC_W-1:0]  sec_reg;
    logic [esc_pkg::YEAR_W-1:0] year_reg;
    logic [3:0]                 month_reg;
    logic [4:0]                 day_reg;
    logic [4:0]                 hour_reg;
    logic [5:0]                 minute_reg;
    logic [5:0]                 second_reg;
    logic [2:0]                 wday_reg;
    logic                       weekend_reg;
    logic                       oor_reg;

    assign last = req_dly_reg[7];

    always_ff @(posedge clk)
    begin
        sec_reg     <= last.action ? c2s_seconds : last.seconds;
        year_reg    <= last.action ? last.year   : s2c_year;
        month_reg   <= last.action ? last.month  : s2c_month;
        day_reg     <= last.action ? last.day    : s2c_day;
        hour_reg    <= last.action ? last.hour   : s2c_hour;
        minute_reg  <= last.action ? last.minute : s2c_minute;
        second_reg  <= last.action ? last.second : s2c_second;
        wday_reg    <= wd_day;
        weekend_reg <= wd_weekend;
        oor_reg     <= last.action & c2s_oor;
    end

    assign done         = vld_reg[8];
    assign seconds_out  = sec_reg;
    assign year_out     = year_reg;
    assign month_out    = month_reg;
    assign day_out      = day_reg;
    assign hour_out     = hour_reg;
    assign minute_out   = minute_reg;
    assign second_out   = second_reg;
    assign weekday      = wday_reg;
    assign is_weekend   = weekend_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire
